FILE: sv/safk_pkg.sv
package safk_pkg;

   localparam int AngleWidth = 20;
   localparam int RotWidth = 32;
   localparam int PosWidth = 25;
   localparam int LenWidth = 12;
   localparam int CordicSteps = 26;
   localparam int CordicWidth = 34;
   localparam int ZWidth = 30;
   localparam int PoseWidth = 34;
   localparam int AddrWidth = 4;
   localparam int DataWidth = 32;
   localparam int NumJoints = 6;

   localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [CordicWidth-1:0] OneQ30 = 34'sd1073741824;
   localparam logic signed [PoseWidth-1:0] PosLimit = 34'sd2147483648;
   localparam logic signed [19:0] TurnUnits = 20'sd368640;
   localparam logic signed [19:0] HalfTurn = 20'sd184320;
   localparam logic signed [19:0] QuarterTurn = 20'sd92160;

   localparam logic [LenWidth-1:0] BaseHeightReset = 12'd491;
   localparam logic [LenWidth-1:0] UpperArmReset = 12'd450;
   localparam logic [LenWidth-1:0] ForearmReset = 12'd450;
   localparam logic [LenWidth-1:0] ToolOffsetReset = 12'd84;

   typedef enum logic [AddrWidth-1:0] {
      REG_BASE_HEIGHT = 4'h0,
      REG_UPPER_ARM = 4'h4,
      REG_FOREARM = 4'h8,
      REG_TOOL_OFFSET = 4'hc
   } reg_addr_type;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [ZWidth-1:0] z;
      logic flip;
   } cordic_type;

   typedef struct packed {
      logic signed [8:0][CordicWidth-1:0] r;
      logic signed [2:0][PoseWidth-1:0] p;
   } pose_type;

   function automatic logic signed [ZWidth-1:0] atan_entry(input int i);
      logic signed [ZWidth-1:0] t [CordicSteps];
      t = '{30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
            30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
            30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
            30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14,
            30'sd7, 30'sd4, 30'sd2};
      return t[i];
   endfunction

   function automatic logic signed [CordicWidth-1:0] clamp_rot(
      input logic signed [69:0] v);
      logic signed [CordicWidth-1:0] r;
      if (v > 70'sd1073741824) begin
         r = OneQ30;
      end else if (v < -70'sd1073741824) begin
         r = -OneQ30;
      end else begin
         r = v[CordicWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [PoseWidth-1:0] clamp_pos(
      input logic signed [69:0] v);
      logic signed [PoseWidth-1:0] r;
      if (v > 70'sd2147483648) begin
         r = PosLimit;
      end else if (v < -70'sd2147483648) begin
         r = -PosLimit;
      end else begin
         r = v[PoseWidth-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/safk_cordic_cell.sv
module safk_cordic_cell import safk_pkg::*; #(
   parameter int Step = 0
) (
   input logic clock,
   input logic enable,
   input cordic_type cell_in,
   output cordic_type cell_out
);

   cordic_type cell_ff, cell_in_v;

   always_comb begin
      cell_in_v = cell_in;
      if (cell_in.z >= 0) begin
         cell_in_v.x = cell_in.x - (cell_in.y >>> Step);
         cell_in_v.y = cell_in.y + (cell_in.x >>> Step);
         cell_in_v.z = cell_in.z - atan_entry(Step);
      end else begin
         cell_in_v.x = cell_in.x + (cell_in.y >>> Step);
         cell_in_v.y = cell_in.y - (cell_in.x >>> Step);
         cell_in_v.z = cell_in.z + atan_entry(Step);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in_v;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: sv/safk_sincos.sv
module safk_sincos import safk_pkg::*; (
   input logic clock,
   input logic enable,
   input logic signed [AngleWidth-1:0] angle,
   output logic signed [CordicWidth-1:0] sin_out,
   output logic signed [CordicWidth-1:0] cos_out
);

   cordic_type chain [CordicSteps+1];
   cordic_type start_ff;
   logic signed [20:0] r0, r1;
   logic flip;

   always_comb begin
      r0 = 21'(angle);
      if (r0 >= 21'(TurnUnits)) begin
         r0 = r0 - 21'(TurnUnits);
      end else if (r0 <= -21'(TurnUnits)) begin
         r0 = r0 + 21'(TurnUnits);
      end
      if (r0 >= 21'(HalfTurn)) begin
         r0 = r0 - 21'(TurnUnits);
      end
      if (r0 < -21'(HalfTurn)) begin
         r0 = r0 + 21'(TurnUnits);
      end
      r1 = r0;
      flip = 1'b0;
      if (r0 > 21'(QuarterTurn)) begin
         r1 = r0 - 21'(HalfTurn);
         flip = 1'b1;
      end else if (r0 < -21'(QuarterTurn)) begin
         r1 = r0 + 21'(HalfTurn);
         flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         start_ff.x <= CordicGain;
         start_ff.y <= '0;
         start_ff.z <= ZWidth'(r1) <<< 10;
         start_ff.flip <= flip;
      end
   end

   assign chain[0] = start_ff;

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
      safk_cordic_cell #(.Step(i)) u_cell (
         .clock(clock), .enable(enable), .cell_in(chain[i]), .cell_out(chain[i+1]));
   end

   always_comb begin
      cos_out = clamp_rot(70'(chain[CordicSteps].flip ? -chain[CordicSteps].x
                                                        : chain[CordicSteps].x));
      sin_out = clamp_rot(70'(chain[CordicSteps].flip ? -chain[CordicSteps].y
                                                        : chain[CordicSteps].y));
   end

endmodule

FILE: sv/safk_compose.sv
module safk_compose import safk_pkg::*; (
   input logic clock,
   input logic enable,
   input pose_type t_in,
   input pose_type g_in,
   output pose_type t_out
);

   logic signed [8:0][69:0] rprod_ff;
   logic signed [2:0][69:0] pprod_ff;
   logic signed [2:0][PoseWidth-1:0] tp_ff;
   pose_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rprod_ff[i*3+j] <= 70'($signed(t_in.r[i*3])) * 70'($signed(g_in.r[j]))
                  + 70'($signed(t_in.r[i*3+1])) * 70'($signed(g_in.r[3+j]))
                  + 70'($signed(t_in.r[i*3+2])) * 70'($signed(g_in.r[6+j]));
            end
            pprod_ff[i] <= 70'($signed(t_in.r[i*3])) * 70'($signed(g_in.p[0]))
               + 70'($signed(t_in.r[i*3+1])) * 70'($signed(g_in.p[1]))
               + 70'($signed(t_in.r[i*3+2])) * 70'($signed(g_in.p[2]));
         end
         tp_ff <= t_in.p;
         out_ff <= out_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         out_in.r[k] = clamp_rot(($signed(rprod_ff[k]) + 70'sd536870912) >>> 30);
      end
      for (int i = 0; i < 3; i++) begin
         out_in.p[i] = clamp_pos((($signed(pprod_ff[i]) + 70'sd536870912) >>> 30)
            + 70'($signed(tp_ff[i])));
      end
   end

   assign t_out = out_ff;

endmodule

FILE: sv/safk_joint_cell.sv
module safk_joint_cell import safk_pkg::*; #(
   parameter int Lead = 0,
   parameter bit AboutY = 1'b0
) (
   input logic clock,
   input logic enable,
   input logic signed [AngleWidth-1:0] angle,
   input logic [LenWidth+1:0] height,
   input pose_type t_in,
   output pose_type t_out
);

   localparam int Lat = CordicSteps + 2;
   logic signed [CordicWidth-1:0] s, c;
   logic signed [AngleWidth-1:0] ang_ff [Lead+1];
   pose_type tdel_ff [Lat+1];
   pose_type g_ff, g_in;

   assign ang_ff[0] = angle;
   for (genvar i = 0; i < Lead; i++) begin : g_lead
      always_ff @(posedge clock) begin
         if (enable) begin
            ang_ff[i+1] <= ang_ff[i];
         end
      end
   end

   safk_sincos u_sc (.clock(clock), .enable(enable), .angle(ang_ff[Lead]),
      .sin_out(s), .cos_out(c));

   assign tdel_ff[0] = t_in;
   for (genvar i = 0; i < Lat; i++) begin : g_tdel
      always_ff @(posedge clock) begin
         if (enable) begin
            tdel_ff[i+1] <= tdel_ff[i];
         end
      end
   end

   always_comb begin
      g_in = '0;
      g_in.r[0] = c;
      g_in.r[8] = AboutY ? c : OneQ30;
      if (AboutY) begin
         g_in.r[2] = s;
         g_in.r[4] = OneQ30;
         g_in.r[6] = -s;
         g_in.p[0] = -PoseWidth'((70'(s) * 70'(height) + 70'sd524288) >>> 20);
         g_in.p[2] = PoseWidth'((70'(OneQ30 - c) * 70'(height) + 70'sd524288) >>> 20);
      end else begin
         g_in.r[1] = -s;
         g_in.r[3] = s;
         g_in.r[4] = c;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         g_ff <= g_in;
      end
   end

   safk_compose u_comp (.clock(clock), .enable(enable), .t_in(tdel_ff[Lat]),
      .g_in(g_ff), .t_out(t_out));

endmodule

FILE: sv/six_axis_forward_kinematics.sv
// Forward kinematics of a six-axis arm: one joint vector in, one tool pose out.
// A new transaction is accepted every cycle unless the output stalls. Each one passes
// through a chain of six joint cells, each a 27-stage cordic pipeline, a joint
// transform register and a two-stage matrix compose, then a two-stage compose
// with the home pose and the output register. The whole pipe advances whenever
// the output register is empty or being taken. The user writes link lengths over
// the csr port only while the block is idle; the block does not enforce this.
module six_axis_forward_kinematics import safk_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic signed [AngleWidth-1:0] req_joint_one_angle,
   input logic signed [AngleWidth-1:0] req_joint_two_angle,
   input logic signed [AngleWidth-1:0] req_joint_three_angle,
   input logic signed [AngleWidth-1:0] req_joint_four_angle,
   input logic signed [AngleWidth-1:0] req_joint_five_angle,
   input logic signed [AngleWidth-1:0] req_joint_six_angle,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic signed [RotWidth-1:0] rsp_rot_row0_col0,
   output logic signed [RotWidth-1:0] rsp_rot_row0_col1,
   output logic signed [RotWidth-1:0] rsp_rot_row0_col2,
   output logic signed [RotWidth-1:0] rsp_rot_row1_col0,
   output logic signed [RotWidth-1:0] rsp_rot_row1_col1,
   output logic signed [RotWidth-1:0] rsp_rot_row1_col2,
   output logic signed [RotWidth-1:0] rsp_rot_row2_col0,
   output logic signed [RotWidth-1:0] rsp_rot_row2_col1,
   output logic signed [RotWidth-1:0] rsp_rot_row2_col2,
   output logic signed [PosWidth-1:0] rsp_pos_x,
   output logic signed [PosWidth-1:0] rsp_pos_y,
   output logic signed [PosWidth-1:0] rsp_pos_z,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [AddrWidth-1:0] csr_paddr,
   input logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int JointLat = CordicSteps + 4;
   localparam int Depth = NumJoints * JointLat + 2;

   logic [LenWidth-1:0] base_ff, upper_ff, fore_ff, tool_ff;
   logic [Depth-1:0] vld_ff;
   logic out_vld_ff;
   logic enable;
   logic [LenWidth+1:0] h2, h3, h5, total;
   pose_type chain [NumJoints+2];
   pose_type ident, home;
   pose_type out_ff;
   logic signed [AngleWidth-1:0] angles [NumJoints];

   assign csr_pready = 1'b1;
   assign enable = !out_vld_ff || rsp_ready;
   assign req_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BaseHeightReset;
         upper_ff <= UpperArmReset;
         fore_ff <= ForearmReset;
         tool_ff <= ToolOffsetReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            REG_BASE_HEIGHT: base_ff <= csr_pwdata[LenWidth-1:0];
            REG_UPPER_ARM: upper_ff <= csr_pwdata[LenWidth-1:0];
            REG_FOREARM: fore_ff <= csr_pwdata[LenWidth-1:0];
            REG_TOOL_OFFSET: tool_ff <= csr_pwdata[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         REG_BASE_HEIGHT: csr_prdata = DataWidth'(base_ff);
         REG_UPPER_ARM: csr_prdata = DataWidth'(upper_ff);
         REG_FOREARM: csr_prdata = DataWidth'(fore_ff);
         REG_TOOL_OFFSET: csr_prdata = DataWidth'(tool_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign h2 = (LenWidth+2)'(base_ff);
   assign h3 = h2 + (LenWidth+2)'(upper_ff);
   assign h5 = h3 + (LenWidth+2)'(fore_ff);
   assign total = h5 + (LenWidth+2)'(tool_ff);

   always_comb begin
      ident = '0;
      ident.r[0] = OneQ30;
      ident.r[4] = OneQ30;
      ident.r[8] = OneQ30;
      home = '0;
      home.r[0] = -OneQ30;
      home.r[4] = -OneQ30;
      home.r[8] = OneQ30;
      home.p[2] = PoseWidth'({total, 10'd0});
   end

   assign chain[0] = ident;
   assign angles[0] = req_joint_one_angle;
   assign angles[1] = req_joint_two_angle;
   assign angles[2] = req_joint_three_angle;
   assign angles[3] = req_joint_four_angle;
   assign angles[4] = req_joint_five_angle;
   assign angles[5] = req_joint_six_angle;

   for (genvar j = 0; j < NumJoints; j++) begin : g_joint
      localparam bit IsY = (j == 1) || (j == 2) || (j == 4);
      logic [LenWidth+1:0] hj;
      assign hj = (j == 1) ? h2 : (j == 2) ? h3 : (j == 4) ? h5 : '0;
      safk_joint_cell #(.Lead(j * JointLat), .AboutY(IsY)) u_joint (
         .clock(clock), .enable(enable), .angle(angles[j]), .height(hj),
         .t_in(chain[j]), .t_out(chain[j+1]));
   end

   safk_compose u_home (.clock(clock), .enable(enable), .t_in(chain[NumJoints]),
      .g_in(home), .t_out(chain[NumJoints+1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= chain[NumJoints+1];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_rot_row0_col0 = RotWidth'(out_ff.r[0]);
   assign rsp_rot_row0_col1 = RotWidth'(out_ff.r[1]);
   assign rsp_rot_row0_col2 = RotWidth'(out_ff.r[2]);
   assign rsp_rot_row1_col0 = RotWidth'(out_ff.r[3]);
   assign rsp_rot_row1_col1 = RotWidth'(out_ff.r[4]);
   assign rsp_rot_row1_col2 = RotWidth'(out_ff.r[5]);
   assign rsp_rot_row2_col0 = RotWidth'(out_ff.r[6]);
   assign rsp_rot_row2_col1 = RotWidth'(out_ff.r[7]);
   assign rsp_rot_row2_col2 = RotWidth'(out_ff.r[8]);

   for (genvar k = 0; k < 3; k++) begin : g_pos
      logic signed [PosWidth-1:0] sat;
      always_comb begin
         if ($signed(out_ff.p[k]) > 34'sd16777215) begin
            sat = 25'sh0ffffff;
         end else if ($signed(out_ff.p[k]) < -34'sd16777216) begin
            sat = 25'sh1000000;
         end else begin
            sat = out_ff.p[k][PosWidth-1:0];
         end
      end
      if (k == 0) begin : g_x
         assign rsp_pos_x = sat;
      end else if (k == 1) begin : g_y
         assign rsp_pos_y = sat;
      end else begin : g_z
         assign rsp_pos_z = sat;
      end
   end

endmodule

FILE: sv/safk_checker.sv
module safk_checker import safk_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [RotWidth-1:0] rsp_rot_row0_col0,
   input logic signed [RotWidth-1:0] rsp_rot_row2_col2,
   input logic csr_pready
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rot_row0_col0))
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepting while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rot_row2_col2 <= 32'sd1073741824
         && rsp_rot_row2_col2 >= -32'sd1073741824)
      else $error("rotation out of range");
   assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind six_axis_forward_kinematics safk_checker u_safk_checker (.*);
